// File: rtl/plst_pkg.sv
// package for the positional list store: sizes, request codes and word types
package plst_pkg;

	localparam int CAPACITY   = 64;
	localparam int ITEM_WIDTH = 32;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int POS_W      = 7;
	localparam int VAL_W      = 32;
	localparam int LEN_W      = 7;
	localparam int CMP_W      = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
	localparam int GRP_SIZE   = 8;
	localparam int NGRP       = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_GET    = 2'd3
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [POS_W-1:0]   position;
		logic [VAL_W-1:0]   item_value;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [VAL_W-1:0]   read_value;
		logic [LEN_W-1:0]   length;
	} rsp_t;

	typedef struct packed {
		logic               ins;
		logic               rem;
		logic               get;
		logic [IDX_W-1:0]   idx;
	} cell_ctl_t;

endpackage

// File: rtl/positional_list_store_core.sv
// top level of the positional list store: request decode, cell row and read merge
//
// Request words come in on req / req_valid, held back by req_stall. Each word
// appends, inserts at a one-based position, removes at a position or reads at
// a position. One response word per request leaves on rsp / rsp_valid, held
// back by rsp_stall; it carries ok, the item read (zero unless a get was
// done) and the list length after the request.
// The list lives in a row of CAPACITY cells; an insert or remove shifts every
// cell at or past the position in the cycle the request is accepted, so the
// next request may follow at once.
// The read item is merged through two registered OR levels (groups of eight
// cells, then the groups); a response passes the cell read register, the group
// register and the response register. Up to three requests are in flight and
// one word per cycle is sustained while rsp_stall is low.
// When rsp_stall is held the response stays put and the stages behind it
// fill; req_stall rises once the first stage cannot move on.
// Reset empties the list and all stages; cell contents need no reset.
module positional_list_store_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  plst_pkg::req_t    req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output plst_pkg::rsp_t    rsp
);
	import plst_pkg::*;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_n;
	logic [CMP_W-1:0]      pos_w;
	logic [CMP_W-1:0]      cnt_w;
	logic                  not_full;
	logic                  ins_pos_ok;
	logic                  sel_pos_ok;
	logic                  ok_n;
	cell_ctl_t             ctl;
	logic                  acc;

	logic [ITEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [ITEM_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [ITEM_WIDTH-1:0] new_value;

	logic                  v1_q, v2_q, v3_q;
	logic                  ld2, ld3;
	logic                  ok_s1, ok_s2;
	logic [CNT_W-1:0]      len_s1, len_s2;
	logic [ITEM_WIDTH-1:0] grp_n [NGRP];
	logic [ITEM_WIDTH-1:0] grp_s2 [NGRP];
	logic [ITEM_WIDTH-1:0] rd_n;
	rsp_t                  rsp_q;

	assign pos_w      = CMP_W'(req.position);
	assign cnt_w      = CMP_W'(count_q);
	assign not_full   = cnt_w < CMP_W'(CAPACITY);
	assign ins_pos_ok = pos_w != '0 && pos_w <= cnt_w + CMP_W'(1);
	assign sel_pos_ok = pos_w != '0 && pos_w <= cnt_w;
	assign new_value  = req.item_value[ITEM_WIDTH-1:0];

	always_comb begin
		ctl     = '0;
		ok_n    = 1'b0;
		count_n = count_q;
		unique case (req.action)
			ACT_APPEND: begin
				ok_n    = not_full;
				ctl.ins = not_full;
				ctl.idx = IDX_W'(cnt_w);
			end
			ACT_INSERT: begin
				ok_n    = not_full && ins_pos_ok;
				ctl.ins = ok_n;
				ctl.idx = IDX_W'(pos_w - CMP_W'(1));
			end
			ACT_REMOVE: begin
				ok_n    = sel_pos_ok;
				ctl.rem = ok_n;
				ctl.idx = IDX_W'(pos_w - CMP_W'(1));
			end
			ACT_GET: begin
				ok_n    = sel_pos_ok;
				ctl.get = ok_n;
				ctl.idx = IDX_W'(pos_w - CMP_W'(1));
			end
			default: begin
				ok_n = 1'b0;
			end
		endcase
		if (ctl.ins) begin
			count_n = count_q + CNT_W'(1);
		end else if (ctl.rem) begin
			count_n = count_q - CNT_W'(1);
		end
	end

	// stage handshake
	assign ld3       = v2_q && (!v3_q || !rsp_stall);
	assign ld2       = v1_q && (!v2_q || ld3);
	assign req_stall = v1_q && !ld2;
	assign acc       = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			v1_q    <= 1'b0;
			v2_q    <= 1'b0;
			v3_q    <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= count_n;
			end
			v1_q <= acc || (v1_q && !ld2);
			v2_q <= ld2 || (v2_q && !ld3);
			v3_q <= ld3 || (v3_q && rsp_stall);
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic [ITEM_WIDTH-1:0] left_v;
			logic [ITEM_WIDTH-1:0] right_v;
			if (gi == 0) begin : g_first
				assign left_v = '0;
			end else begin : g_mid_l
				assign left_v = cell_data[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_v = '0;
			end else begin : g_mid_r
				assign right_v = cell_data[gi+1];
			end
			plst_cell u_cell (
				.clk       (clk),
				.ld        (acc),
				.ctl       (ctl),
				.index     (IDX_W'(gi)),
				.new_value (new_value),
				.left      (left_v),
				.right     (right_v),
				.data      (cell_data[gi]),
				.rd        (cell_rd[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_s1  <= ok_n;
			len_s1 <= count_n;
		end
	end

	// group merge
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_n[g] = '0;
			for (int j = 0; j < GRP_SIZE; j++) begin
				if (g * GRP_SIZE + j < CAPACITY) begin
					grp_n[g] = grp_n[g] | cell_rd[g * GRP_SIZE + j];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			ok_s2  <= ok_s1;
			len_s2 <= len_s1;
			for (int g = 0; g < NGRP; g++) begin
				grp_s2[g] <= grp_n[g];
			end
		end
	end

	always_comb begin
		rd_n = '0;
		for (int g = 0; g < NGRP; g++) begin
			rd_n = rd_n | grp_s2[g];
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			rsp_q.ok         <= ok_s2;
			rsp_q.read_value <= VAL_W'(rd_n);
			rsp_q.length     <= LEN_W'(len_s2);
		end
	end

	assign rsp_valid = v3_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("list length beyond capacity");

	a_append_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.action == ACT_APPEND && CMP_W'(count_q) < CMP_W'(CAPACITY))
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append not counted");

	a_refused_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !ok_n) |=> $stable(count_q))
		else $error("refused request changed the length");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.ok) |-> rsp.read_value == '0)
		else $error("refused response carries data");

	a_stall_means_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (v1_q && v2_q && v3_q && rsp_stall))
		else $error("request stalled with room in the pipeline");

endmodule

// File: rtl/plst_cell.sv
// one list cell: holds one item, shifts to or from its neighbours, offers it for a read
module plst_cell (
	input  logic                                clk,
	input  logic                                ld,
	input  plst_pkg::cell_ctl_t                 ctl,
	input  logic [plst_pkg::IDX_W-1:0]          index,
	input  logic [plst_pkg::ITEM_WIDTH-1:0]     new_value,
	input  logic [plst_pkg::ITEM_WIDTH-1:0]     left,
	input  logic [plst_pkg::ITEM_WIDTH-1:0]     right,
	output logic [plst_pkg::ITEM_WIDTH-1:0]     data,
	output logic [plst_pkg::ITEM_WIDTH-1:0]     rd
);
	import plst_pkg::*;

	logic [ITEM_WIDTH-1:0] data_q;
	logic [ITEM_WIDTH-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (ld) begin
			priority if (ctl.ins && index == ctl.idx) begin
				data_q <= new_value;
			end else if (ctl.ins && index > ctl.idx) begin
				data_q <= left;
			end else if (ctl.rem && index >= ctl.idx) begin
				data_q <= right;
			end else begin
				data_q <= data_q;
			end
			rd_s1 <= (ctl.get && index == ctl.idx) ? data_q : '0;
		end
	end

	assign data = data_q;
	assign rd   = rd_s1;

endmodule

// File: tb/sv/tb_positional_list_store_core.sv
// testbench for positional_list_store_core: list predictor, random traffic and response checks
`timescale 1ns / 1ps

module tb_positional_list_store_core;

	import plst_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRINT_LIMIT    = 200;
	localparam logic [VAL_W-1:0] KEEP_MASK = VAL_W'((65'd1 << ITEM_WIDTH) - 65'd1);

	logic clk;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [VAL_W-1:0] list_items[$];
	rsp_t             rsp_expected[$];
	int               errors      = 0;
	int               idle_cycles = 0;
	int               hold_left   = 0;
	bit               tx_idle_on  = 1'b1;
	bit               rx_idle_on  = 1'b1;

	positional_list_store_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic rsp_t list_apply(input req_t w);
		rsp_t             r;
		logic [VAL_W-1:0] v;
		int               p;
		int               n;
		r = '0;
		v = w.item_value & KEEP_MASK;
		p = int'(w.position);
		n = list_items.size();
		case (w.action)
			ACT_APPEND: begin
				if (n < CAPACITY) begin
					list_items.push_back(v);
					r.ok = 1'b1;
				end
			end
			ACT_INSERT: begin
				if (n < CAPACITY && p >= 1 && p <= n + 1) begin
					if (p == n + 1)
						list_items.push_back(v);
					else
						list_items.insert(p - 1, v);
					r.ok = 1'b1;
				end
			end
			ACT_REMOVE: begin
				if (p >= 1 && p <= n) begin
					list_items.delete(p - 1);
					r.ok = 1'b1;
				end
			end
			default: begin
				if (p >= 1 && p <= n) begin
					r.read_value = list_items[p - 1];
					r.ok = 1'b1;
				end
			end
		endcase
		r.length = LEN_W'(list_items.size());
		return r;
	endfunction

	function automatic req_t make_word(input action_t a, input int p, input logic [VAL_W-1:0] v);
		req_t w;
		w.action     = a;
		w.position   = POS_W'(p);
		w.item_value = v;
		return w;
	endfunction

	// random word, positions mostly in range for the current list
	function automatic req_t pick_word(input int grow_pct, input int shrink_pct);
		req_t w;
		int   n;
		int   roll;
		n = list_items.size();
		roll = $urandom_range(99);
		w.item_value = $urandom;
		case ($urandom_range(15))
			0: w.item_value = '0;
			1: w.item_value = '1;
			default: ;
		endcase
		if (roll < grow_pct)
			w.action = $urandom_range(1) ? ACT_APPEND : ACT_INSERT;
		else if (roll < grow_pct + shrink_pct)
			w.action = ACT_REMOVE;
		else
			w.action = ACT_GET;
		if ($urandom_range(9) == 0)
			w.position = POS_W'(($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(65));
		else if (w.action == ACT_INSERT)
			w.position = POS_W'($urandom_range(n + 1, 1));
		else if (w.action == ACT_APPEND)
			w.position = POS_W'($urandom_range(127));
		else
			w.position = POS_W'($urandom_range((n > 0) ? n : 1, 1));
		return w;
	endfunction

	task automatic send_word(input req_t w);
		while (tx_idle_on && $urandom_range(99) < 20) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= w;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		rsp_expected.push_back(list_apply(w));
	endtask

	task automatic note_mismatch(input string field, input logic [VAL_W-1:0] want,
			input logic [VAL_W-1:0] got);
		if (errors < PRINT_LIMIT)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		errors++;
	endtask

	// receiver stall: random, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			rsp_stall <= rx_idle_on && ($urandom_range(99) < 20);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (rsp_expected.size() == 0) begin
				if (errors < PRINT_LIMIT)
					$display("%0t: unexpected word, expected none, actual ok %0b read %0h length %0d",
						$time, rsp.ok, rsp.read_value, rsp.length);
				errors++;
			end else begin
				want = rsp_expected.pop_front();
				if (rsp.ok !== want.ok)
					note_mismatch("ok", VAL_W'(want.ok), VAL_W'(rsp.ok));
				if (rsp.read_value !== want.read_value)
					note_mismatch("read_value", want.read_value, rsp.read_value);
				if (rsp.length !== want.length)
					note_mismatch("length", VAL_W'(want.length), VAL_W'(rsp.length));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid === 1'b1 && req_stall === 1'b0) || (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic test_empty_list();
		send_word(make_word(ACT_GET, 1, '0));
		send_word(make_word(ACT_REMOVE, 1, '1));
		send_word(make_word(ACT_GET, 0, '0));
		send_word(make_word(ACT_INSERT, 0, 32'hDEAD_BEEF));
		send_word(make_word(ACT_INSERT, 2, 32'hDEAD_BEEF));
		send_word(make_word(ACT_INSERT, 1, 32'h1234_5678));
		send_word(make_word(ACT_GET, 1, '0));
		send_word(make_word(ACT_REMOVE, 1, '0));
		send_word(make_word(ACT_GET, 127, '0));
	endtask

	task automatic test_value_extremes();
		send_word(make_word(ACT_APPEND, 127, '0));
		send_word(make_word(ACT_APPEND, 0, '1));
		send_word(make_word(ACT_INSERT, 1, 32'hAAAA_AAAA));
		send_word(make_word(ACT_INSERT, 4, 32'h5555_5555));
		send_word(make_word(ACT_INSERT, 6, 32'h0F0F_0F0F));
		for (int p = 1; p <= 4; p++)
			send_word(make_word(ACT_GET, p, '0));
		send_word(make_word(ACT_REMOVE, 2, '0));
		send_word(make_word(ACT_GET, 2, '0));
		send_word(make_word(ACT_GET, 4, '0));
		send_word(make_word(ACT_REMOVE, 3, '0));
		send_word(make_word(ACT_REMOVE, 3, '0));
	endtask

	task automatic test_full_list();
		while (list_items.size() < CAPACITY)
			send_word(make_word(ACT_APPEND, $urandom_range(127), $urandom));
		send_word(make_word(ACT_APPEND, 0, '1));
		send_word(make_word(ACT_INSERT, 1, '1));
		send_word(make_word(ACT_INSERT, 65, '0));
		send_word(make_word(ACT_GET, 64, '0));
		send_word(make_word(ACT_GET, 65, '0));
		send_word(make_word(ACT_REMOVE, 64, '0));
		send_word(make_word(ACT_INSERT, 64, 32'hC0FF_EE00));
		send_word(make_word(ACT_REMOVE, 127, '0));
		send_word(make_word(ACT_REMOVE, 1, '0));
		send_word(make_word(ACT_GET, 63, '0));
	endtask

	task automatic test_back_to_back(input int n_words);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		repeat (n_words)
			send_word(pick_word(35, 35));
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		@(posedge clk);
		hold_left = 80;
		tx_idle_on = 1'b0;
		repeat (24)
			send_word(pick_word(70, 10));
		tx_idle_on = 1'b1;
	endtask

	// phases that grow, shrink or churn the list
	task automatic test_random_traffic(input int n_words);
		int done;
		int span;
		int grow;
		int shrink;
		done = 0;
		while (done < n_words) begin
			case ($urandom_range(2))
				0: begin
					grow = 60;
					shrink = 15;
				end
				1: begin
					grow = 15;
					shrink = 60;
				end
				default: begin
					grow = 35;
					shrink = 35;
				end
			endcase
			span = $urandom_range(120, 30);
			repeat (span)
				send_word(pick_word(grow, shrink));
			done += span;
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		test_empty_list();
		test_value_extremes();
		test_full_list();
		test_back_to_back(150);
		test_backpressure();
		test_random_traffic(650);
		@(negedge clk);
		req_valid <= 1'b0;
		while (rsp_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
